@@ rtl/sptr_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial port package
// Shared payload types, operation codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sptr_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_WRITE_TX    = 3'd0;
    localparam logic [2:0] FUNC_READ_STATUS = 3'd1;
    localparam logic [2:0] FUNC_TICK        = 3'd2;
    localparam logic [2:0] FUNC_RX_BYTE     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR_RX    = 3'd4;

    // Configuration register indexes.
    localparam logic REG_PERIOD  = 1'b0;
    localparam logic REG_INSTANT = 1'b1;

    localparam int PERIOD_W = 15;
    localparam int CYCLES_W = 19;
    localparam int CFG_W    = 15;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] tx_word;
        logic [31:0] elapsed;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] status;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tbe_irq;
        logic        rbf_irq;
    } t_out_item;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_minus_one;
        logic                instant_mode;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/sptr_core.sv @@
// ----------------------------------------------------------------------------
// Serial port core
// Holds the port state and computes one operation's result and next state.
// ----------------------------------------------------------------------------
`default_nettype none

module sptr_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  sptr_pkg::t_in_item   i_item,
    input  sptr_pkg::t_cfg       i_cfg,
    output sptr_pkg::t_out_item  o_result
);
    import sptr_pkg::*;

    logic [15:0]         r_hold_word,  n_hold_word;
    logic                r_hold_valid, n_hold_valid;
    logic                r_busy,       n_busy;
    logic [CYCLES_W-1:0] r_cycles,     n_cycles;
    logic [8:0]          r_rx_data,    n_rx_data;
    logic                r_rx_full,    n_rx_full;
    logic                r_overrun,    n_overrun;
    logic                r_line,       n_line;

    logic [CYCLES_W-1:0] frame_len;
    logic [CYCLES_W-1:0] bit_time;
    logic                do_load;
    logic                txv;
    logic [7:0]          txb;
    logic                tbe;
    logic                rbf;

    // A frame is ten bit times: (p + 1) * 8 + (p + 1) * 2.
    assign bit_time  = CYCLES_W'(i_cfg.period_minus_one) + CYCLES_W'(1);
    assign frame_len = (bit_time << 3) + (bit_time << 1);

    always_comb begin
        n_hold_word  = r_hold_word;
        n_hold_valid = r_hold_valid;
        n_busy       = r_busy;
        n_cycles     = r_cycles;
        n_rx_data    = r_rx_data;
        n_rx_full    = r_rx_full;
        n_overrun    = r_overrun;
        n_line       = r_line;
        do_load      = 1'b0;
        txv          = 1'b0;
        txb          = 8'd0;
        tbe          = 1'b0;
        rbf          = 1'b0;

        unique case (i_item.func)
            FUNC_WRITE_TX: begin
                if (i_cfg.instant_mode) begin
                    txv = 1'b1;
                    txb = i_item.tx_word[7:0];
                    tbe = 1'b1;
                end else begin
                    n_hold_word  = i_item.tx_word;
                    n_hold_valid = 1'b1;
                    do_load      = !r_busy;
                end
            end
            FUNC_TICK: begin
                if (!r_busy) begin
                    do_load = r_hold_valid;
                end else if (i_item.elapsed >= 32'(r_cycles)) begin
                    n_cycles = '0;
                    n_busy   = 1'b0;
                    do_load  = r_hold_valid;
                end else begin
                    n_cycles = r_cycles - i_item.elapsed[CYCLES_W-1:0];
                end
            end
            FUNC_RX_BYTE: begin
                if (r_rx_full) begin
                    n_overrun = 1'b1;
                end
                n_rx_data = {1'b1, i_item.rx_byte};
                n_rx_full = 1'b1;
                n_line    = 1'b1;
                rbf       = 1'b1;
            end
            FUNC_CLEAR_RX: begin
                n_rx_full = 1'b0;
                n_rx_data = '0;
                n_overrun = 1'b0;
            end
            default: begin
            end
        endcase

        // The hold word moves into the shift stage and goes out on the line.
        if (do_load) begin
            n_busy       = 1'b1;
            n_cycles     = frame_len;
            n_hold_valid = 1'b0;
            txv          = 1'b1;
            txb          = n_hold_word[7:0];
            tbe          = 1'b1;
        end
    end

    always_comb begin
        o_result.status   = {n_overrun, n_rx_full, !n_hold_valid, !n_busy, n_line,
                             1'b0, 1'b0, n_rx_data};
        o_result.tx_valid = txv;
        o_result.tx_byte  = txb;
        o_result.tbe_irq  = tbe;
        o_result.rbf_irq  = rbf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_word  <= '0;
            r_hold_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_cycles     <= '0;
            r_rx_data    <= '0;
            r_rx_full    <= 1'b0;
            r_overrun    <= 1'b0;
            r_line       <= 1'b1;
        end else if (i_fire) begin
            r_hold_word  <= n_hold_word;
            r_hold_valid <= n_hold_valid;
            r_busy       <= n_busy;
            r_cycles     <= n_cycles;
            r_rx_data    <= n_rx_data;
            r_rx_full    <= n_rx_full;
            r_overrun    <= n_overrun;
            r_line       <= n_line;
        end
    end

    // A busy shift stage always has cycles left in its frame.
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cycles != '0))
        else $error("shift stage busy with no cycles left");

    // The receive marker bit tracks receive-full exactly.
    a_rx_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_data[8] == r_rx_full)
        else $error("receive marker and receive-full disagree");

    // Overrun can only be set while a byte is held.
    a_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overrun |-> r_rx_full)
        else $error("overrun set without receive-full");

endmodule

`default_nettype wire

@@ rtl/serial_port_tx_rx_registers.sv @@
// An accepted item passes through the input register and then the result register before its result is offered.
// Throughput: one item per cycle; the input register, the single-pass state update
// and the result register form a two-stage pipeline that advances whenever
// the result register is empty or its result is taken in the same cycle.
// Reset (i_rst_n low at a clock edge) empties both stages, restores the port
// state and sets the bit period to one (period_minus_one zero) and instant mode to one.
// ----------------------------------------------------------------------------
// Serial port transmit/receive registers
// Register-level serial port: transmit writes, status reads, time ticks,
// received bytes and receive-full clears, one result word per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_port_tx_rx_registers (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  sptr_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output sptr_pkg::t_out_item               o_out_data,
    input  wire                               i_cfg_we,
    input  wire                               i_cfg_index,
    input  wire [sptr_pkg::CFG_W-1:0]         i_cfg_data
);
    import sptr_pkg::*;

    // Input stage: one registered item waiting for the state update.
    logic      r_in_valid;
    t_in_item  r_in;
    // Result stage: one finished result waiting to be taken downstream.
    logic      r_out_valid;
    t_out_item r_out;
    // Configuration registers.
    t_cfg      r_cfg;

    logic      advance;
    t_out_item core_result;

    // The item in the input stage moves on when the result register can
    // take its result; the input stage refills in the same cycle.
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    // Configuration writes land at once; the user must write them only while idle, as the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_minus_one <= '0;
            r_cfg.instant_mode     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PERIOD:  r_cfg.period_minus_one <= i_cfg_data[PERIOD_W-1:0];
                REG_INSTANT: r_cfg.instant_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // State update for one operation, committed when the item advances.
    sptr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Every byte sent raises the transmit-empty interrupt and vice versa.
    a_tx_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.tx_valid == r_out.tbe_irq))
        else $error("transmit byte and interrupt disagree");

    // The byte field reads zero when nothing was sent.
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.tx_valid) |-> (r_out.tx_byte == 8'd0))
        else $error("byte reported without a send");

    // A result is only produced by an item that came through the input stage.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> $past(r_in_valid))
        else $error("result appeared without an item");

endmodule

`default_nettype wire
